// File: hdl/frd_pkg.sv
// Shared types and constants of the flag-bit run-length column image decoder.
package frd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 11;
    localparam int INDEX_W    = 22;
    localparam int LEN_W      = 23;
    localparam int TOK_W      = 16;
    localparam int TCNT_W     = 5;
    localparam int RUNN_W     = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int SLOTS      = 4;
    localparam int SLOT_CNT_W = 3;

    localparam logic [WIDTH_W-1:0]  MAX_WIDTH    = 13'd4096;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT   = 11'd1024;
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 13'd2160;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 11'd360;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              frame_start;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic               plane;
        logic [INDEX_W-1:0] start_index;
        logic [LEN_W-1:0]   run_length;
        logic [BYTE_W-1:0]  pixel_value;
        logic               frame_done;
    } t_run;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_write;

endpackage

// File: hdl/frd_ifs.sv
// Valid/ready channel interfaces for compressed bytes, runs and register writes.
interface frd_in_if;
    import frd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frd_run_if;
    import frd_pkg::*;
    logic valid;
    logic ready;
    t_run data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frd_cfg_if;
    import frd_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/flag_rle_column_image_decoder.sv
// Flag-bit run-length decoder: compressed bytes in, column-major run descriptors out.
//
// i_in carries one compressed byte per item with frame_start and last_byte flags.
// o_run carries one run descriptor per item: plane, start index, length, value and
// frame_done on the run that completes the top plane. i_cfg writes image_width
// (index 0) and image_height (index 1); it is ready out of reset and is to be written
// by the user only while idle, which the block does not enforce. A byte is held in
// the input register r_in, decoded there against the token and position state, and
// its runs are loaded into a four-entry result buffer that drives o_run. One byte is
// taken every cycle while each byte gives at most one run and o_run does not stall;
// a last byte gives up to four runs, which leave at one per cycle while o_run is
// ready, and a next byte with runs waits in the input register until the buffer
// holds no more than one run that is leaving. The loop that sets the rate is the
// position update from one byte to the next (remaining-pixel subtract and clip compare).
// When o_run stalls the buffer holds its runs; i_in keeps taking bytes that finish
// no token and stops at the first byte that has runs to add.
// Synchronous reset clears the token state, plane, position, the buffer and
// restores the size registers to 2160 by 360; i_in and i_cfg are not ready in reset.
module flag_rle_column_image_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    frd_in_if.sink    i_in,
    frd_run_if.source o_run,
    frd_cfg_if.sink   i_cfg
);
    import frd_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [LEN_W-1:0]    r_size;
    logic [WIDTH_W-1:0]  w_cl;
    logic [HEIGHT_W-1:0] h_cl;
    logic [WIDTH_W+HEIGHT_W-1:0] size_full;

    logic     r_in_valid;
    t_in_item r_in;

    logic [TOK_W-1:0]   r_tok,   n_tok;
    logic [TCNT_W-1:0]  r_tcnt,  n_tcnt;
    logic               r_plane, n_plane;
    logic [INDEX_W-1:0] r_pos,   n_pos;
    logic               r_done,  n_done;

    t_run                  r_slot [SLOTS];
    logic [SLOT_CNT_W-1:0] r_slot_n;
    t_run                  slot_new [SLOTS];
    logic [SLOT_CNT_W-1:0] k_cnt;

    logic out_fire, advance;

    // effective state after an optional frame restart
    logic [TCNT_W-1:0]  c, c_m1, need, cnt_a;
    logic [TOK_W-1:0]   tb, tok_a;
    logic               p0, dn0;
    logic [INDEX_W-1:0] pos0;
    logic               flag, complete;
    logic [2:0]         shift;
    logic [23:0]        full, acc_k;
    logic [RUNN_W-1:0]  n_a, n_ae, n_b, n_ab;
    logic [BYTE_W-1:0]  pix_a, pix_b, byte_mask;

    logic [TCNT_W-1:0]  pm1, psh5;
    logic               pflag;
    logic [RUNN_W-1:0]  runc9;
    logic [TOK_W-1:0]   pshifted;
    logic [BYTE_W-1:0]  pmask;

    logic [LEN_W-1:0]   rem0, rem_a, rem_bc, rem_s, len_a, len_b;
    logic [INDEX_W-1:0] pos_a, pos_bc, pos_s;
    logic               ends_a, ends_b, switched_a, plane_a, done_a, plane_s, done_s;
    logic               has_a, has_b, has_f1, has_f2;
    t_run               cand [SLOTS];
    logic [SLOTS-1:0]   cand_v;

    function automatic logic run_ends(input logic [LEN_W-1:0] rem, input logic [RUNN_W-1:0] n);
        return (rem[LEN_W-1:RUNN_W] == '0) && (rem[RUNN_W-1:0] <= n);
    endfunction

    // configuration and plane size
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data.value[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg.data.value[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cl = (r_width == '0) ? WIDTH_W'(1) : (r_width > MAX_WIDTH) ? MAX_WIDTH : r_width;
    assign h_cl = (r_height == '0) ? HEIGHT_W'(1) :
                  (r_height > MAX_HEIGHT) ? MAX_HEIGHT : r_height;
    assign size_full = {{HEIGHT_W{1'b0}}, w_cl} * {{WIDTH_W{1'b0}}, h_cl};

    always_ff @(posedge i_clk) begin
        r_size <= size_full[LEN_W-1:0];
    end

    // handshakes
    assign o_run.valid = (r_slot_n != '0);
    assign o_run.data  = r_slot[0];
    assign out_fire    = o_run.valid && o_run.ready;
    assign advance     = r_in_valid && ((k_cnt == '0) || (r_slot_n == '0) ||
                         ((r_slot_n == SLOT_CNT_W'(1)) && out_fire));
    assign i_in.ready  = i_rst_n && (!r_in_valid || advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // token gathering for one byte
    always_comb begin
        c    = r_in.frame_start ? '0 : r_tcnt;
        tb   = r_in.frame_start ? '0 : r_tok;
        p0   = r_in.frame_start ? 1'b0 : r_plane;
        pos0 = r_in.frame_start ? '0 : r_pos;
        dn0  = r_in.frame_start ? 1'b0 : r_done;

        c_m1     = c - TCNT_W'(1);
        flag     = (c == '0) ? r_in.stream_byte[BYTE_W-1] : tb[c_m1[3:0]];
        need     = (flag ? TCNT_W'(17) : TCNT_W'(9)) - c;
        complete = !dn0 && (need <= TCNT_W'(8));
        shift    = 3'(TCNT_W'(8) - need);
        full     = {tb, r_in.stream_byte};
        acc_k    = full >> shift;
        n_a      = flag ? ({1'b0, acc_k[15:8]} + RUNN_W'(1)) : RUNN_W'(1);
        pix_a    = acc_k[7:0];

        // bits left over after a completed token start the next one
        byte_mask = (BYTE_W'(1) << shift) - BYTE_W'(1);
        if (complete) begin
            cnt_a = {2'b00, shift};
            tok_a = {8'd0, r_in.stream_byte & byte_mask};
        end else begin
            cnt_a = c + TCNT_W'(8);
            tok_a = full[TOK_W-1:0];
        end

        // partial token closed by the last byte
        pm1      = cnt_a - TCNT_W'(1);
        pflag    = tok_a[pm1[3:0]];
        runc9    = tok_a[8:0] & ~(RUNN_W'(1) << pm1[3:0]);
        psh5     = cnt_a - TCNT_W'(9);
        pshifted = tok_a >> psh5[2:0];
        pmask    = (BYTE_W'(1) << psh5[2:0]) - BYTE_W'(1);
        if (!pflag) begin
            n_b   = RUNN_W'(1);
            pix_b = tok_a[7:0];
        end else if (cnt_a <= TCNT_W'(9)) begin
            n_b   = {1'b0, runc9[7:0]} + RUNN_W'(1);
            pix_b = '0;
        end else begin
            n_b   = {1'b0, pshifted[7:0]} + RUNN_W'(1);
            pix_b = tok_a[7:0] & pmask;
        end
    end

    // run placement and clipping
    always_comb begin
        rem0 = (r_size > {1'b0, pos0}) ? (r_size - {1'b0, pos0}) : LEN_W'(1);
        n_ae = complete ? n_a : '0;
        n_ab = n_ae + n_b;

        has_a      = complete;
        ends_a     = has_a && run_ends(rem0, n_a);
        len_a      = ends_a ? rem0 : {{(LEN_W-RUNN_W){1'b0}}, n_a};
        switched_a = ends_a && !p0;
        if (switched_a) begin
            plane_a = 1'b1;
            pos_a   = '0;
            rem_a   = r_size;
            done_a  = 1'b0;
            pos_bc  = {{(INDEX_W-RUNN_W){1'b0}}, n_b};
            rem_bc  = r_size - {{(LEN_W-RUNN_W){1'b0}}, n_b};
        end else begin
            plane_a = p0;
            pos_a   = ends_a ? '0 : pos0 + {{(INDEX_W-RUNN_W){1'b0}}, n_ae};
            rem_a   = rem0 - {{(LEN_W-RUNN_W){1'b0}}, n_ae};
            done_a  = ends_a;
            pos_bc  = pos0 + {{(INDEX_W-RUNN_W){1'b0}}, n_ab};
            rem_bc  = rem0 - {{(LEN_W-RUNN_W){1'b0}}, n_ab};
        end

        has_b  = r_in.last_byte && !dn0 && !done_a && (cnt_a != '0);
        ends_b = has_b && run_ends(rem_a, n_b);
        len_b  = ends_b ? rem_a : {{(LEN_W-RUNN_W){1'b0}}, n_b};
        if (!has_b) begin
            plane_s = plane_a;
            pos_s   = pos_a;
            rem_s   = rem_a;
            done_s  = done_a;
        end else if (ends_b) begin
            plane_s = 1'b1;
            pos_s   = '0;
            rem_s   = r_size;
            done_s  = plane_a;
        end else begin
            plane_s = plane_a;
            pos_s   = pos_bc;
            rem_s   = rem_bc;
            done_s  = 1'b0;
        end

        has_f1 = r_in.last_byte && !dn0 && !done_s;
        has_f2 = has_f1 && !plane_s;

        cand[0] = '{plane: p0, start_index: pos0, run_length: len_a,
                    pixel_value: pix_a, frame_done: ends_a && p0};
        cand[1] = '{plane: plane_a, start_index: pos_a, run_length: len_b,
                    pixel_value: pix_b, frame_done: ends_b && plane_a};
        cand[2] = '{plane: plane_s, start_index: pos_s, run_length: rem_s,
                    pixel_value: '0, frame_done: plane_s};
        cand[3] = '{plane: 1'b1, start_index: '0, run_length: r_size,
                    pixel_value: '0, frame_done: 1'b1};
        cand_v  = {has_f2, has_f1, has_b, has_a};
    end

    // pack present runs to the front of the buffer
    always_comb begin
        k_cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_new[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (cand_v[i]) begin
                slot_new[k_cnt[1:0]] = cand[i];
                k_cnt = k_cnt + SLOT_CNT_W'(1);
            end
        end
    end

    // decoder state for the next byte
    always_comb begin
        n_tok   = tb;
        n_tcnt  = c;
        n_plane = p0;
        n_pos   = pos0;
        n_done  = dn0;
        if (!dn0) begin
            if (r_in.last_byte) begin
                n_tok   = '0;
                n_tcnt  = '0;
                n_plane = 1'b0;
                n_pos   = '0;
                n_done  = 1'b1;
            end else begin
                n_tok   = tok_a;
                n_tcnt  = cnt_a;
                n_plane = plane_a;
                n_pos   = pos_a;
                n_done  = done_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_tcnt  <= '0;
            r_plane <= 1'b0;
            r_pos   <= '0;
            r_done  <= 1'b0;
        end else if (advance) begin
            r_tok   <= n_tok;
            r_tcnt  <= n_tcnt;
            r_plane <= n_plane;
            r_pos   <= n_pos;
            r_done  <= n_done;
        end
    end

    // result buffer: load a byte's runs, or shift one out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_n <= '0;
        end else if (advance && (k_cnt != '0)) begin
            r_slot_n <= k_cnt;
        end else if (out_fire) begin
            r_slot_n <= r_slot_n - SLOT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && (k_cnt != '0)) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= slot_new[i];
            end
        end else if (out_fire) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

endmodule

// File: hdl/frd_checker.sv
// Port-level checks for the run-length decoder and their binding to the top level.
module frd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input frd_pkg::t_run i_out_data
);
    import frd_pkg::*;

    logic r_after_done;

    // mark that the last run taken closed a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_done <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_after_done <= i_out_data.frame_done;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("run channel valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled run item changed or dropped");

    a_new_frame_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_after_done |-> !i_out_data.plane && (i_out_data.start_index == '0))
        else $error("run after a finished frame does not start at the bottom plane origin");

endmodule

bind flag_rle_column_image_decoder frd_checker u_frd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_run.valid),
    .i_out_ready (o_run.ready),
    .i_out_data  (o_run.data)
);
